[src/pbu_pkg.sv]
// ----------------------------------------------------------------------------
// pbu_pkg: shared types and constants for the belief update block
// Item and result structs, item opcodes, datapath commands, fixed widths.
// ----------------------------------------------------------------------------
package pbu_pkg;

  // Default sizing
  localparam int NUM_STATES_DEF       = 2;
  localparam int NUM_ACTIONS_DEF      = 4;
  localparam int NUM_OBSERVATIONS_DEF = 4;
  localparam int MAX_ALPHAS_DEF       = 16;

  // Fixed widths
  localparam int PW  = 17;  // Q1.16 probability
  localparam int SW  = 34;  // sum of two products
  localparam int UW  = 51;  // observation * sum
  localparam int TW  = 52;  // total of two unnormalized values
  localparam int RW  = 53;  // divider remainder
  localparam int QW  = 16;  // quotient bits
  localparam int AVW = 51;  // alpha value, Q19.32
  localparam int CW  = 5;   // alpha_count register
  localparam int DIV_STEPS = 16;

  localparam logic [PW-1:0] ONE_Q16  = 17'd65536;
  localparam logic [PW-1:0] HALF_Q16 = 17'd32768;

  // Item opcodes
  localparam logic [2:0] OP_RESET  = 3'd0;
  localparam logic [2:0] OP_TRANS  = 3'd1;
  localparam logic [2:0] OP_OBS    = 3'd2;
  localparam logic [2:0] OP_ALPHA  = 3'd3;
  localparam logic [2:0] OP_UPDATE = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_TOT = 2'd1;
  localparam logic [1:0] ST_NO_LINES = 2'd2;

  // Datapath commands
  localparam logic [4:0] DP_NOP    = 5'd0;
  localparam logic [4:0] DP_LOAD   = 5'd1;
  localparam logic [4:0] DP_BRESET = 5'd2;
  localparam logic [4:0] DP_WRITE  = 5'd3;
  localparam logic [4:0] DP_RD0    = 5'd4;
  localparam logic [4:0] DP_RD1    = 5'd5;
  localparam logic [4:0] DP_M1     = 5'd6;
  localparam logic [4:0] DP_ADD    = 5'd7;
  localparam logic [4:0] DP_ML     = 5'd8;
  localparam logic [4:0] DP_MH     = 5'd9;
  localparam logic [4:0] DP_U      = 5'd10;
  localparam logic [4:0] DP_TOT    = 5'd11;
  localparam logic [4:0] DP_DINIT  = 5'd12;
  localparam logic [4:0] DP_DSTEP  = 5'd13;
  localparam logic [4:0] DP_DRND   = 5'd14;
  localparam logic [4:0] DP_COMMIT = 5'd15;
  localparam logic [4:0] DP_ARD    = 5'd16;
  localparam logic [4:0] DP_AMUL   = 5'd17;
  localparam logic [4:0] DP_ACMP   = 5'd18;
  localparam logic [4:0] DP_OUT    = 5'd19;

  typedef struct packed {
    logic [2:0]         action;
    logic               from_state;
    logic               to_state;
    logic [1:0]         act_index;
    logic [1:0]         obs_index;
    logic [16:0]        probability;
    logic [3:0]         alpha_slot;
    logic [3:0]         alpha_choice;
    logic signed [31:0] alpha_slope;
    logic signed [31:0] alpha_intercept;
  } in_item_t;

  typedef struct packed {
    logic [16:0] belief_first;
    logic [16:0] belief_second;
    logic [3:0]  chosen_action;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [4:0] op;
    logic       j;         // target state of the current step
    logic       first;     // first alpha line of the scan
    logic       no_lines;  // effective alpha count is zero
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;        // opcode of the held item
    logic       tot_zero;
    logic       out_free;
  } sts_t;

endpackage

[src/pbu_ram.sv]
// ----------------------------------------------------------------------------
// pbu_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pbu_ctrl.sv]
// ----------------------------------------------------------------------------
// pbu_ctrl: sequencer for the belief update block
// Walks each item through load, then a table write, a belief reset or an update.
// ----------------------------------------------------------------------------
module pbu_ctrl #(
  parameter int MAX_ALPHAS = pbu_pkg::MAX_ALPHAS_DEF,
  parameter int CNTW       = $clog2(MAX_ALPHAS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_data,
  output pbu_pkg::cmd_t        cmd,
  output logic [CNTW-1:0]      k,
  input  pbu_pkg::sts_t        sts
);
  import pbu_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_RD0    = 5'd2;
  localparam logic [4:0] S_RD1    = 5'd3;
  localparam logic [4:0] S_M1     = 5'd4;
  localparam logic [4:0] S_ADD    = 5'd5;
  localparam logic [4:0] S_ML     = 5'd6;
  localparam logic [4:0] S_MH     = 5'd7;
  localparam logic [4:0] S_U      = 5'd8;
  localparam logic [4:0] S_TOT    = 5'd9;
  localparam logic [4:0] S_CHK    = 5'd10;
  localparam logic [4:0] S_DINIT  = 5'd11;
  localparam logic [4:0] S_DSTEP  = 5'd12;
  localparam logic [4:0] S_DRND   = 5'd13;
  localparam logic [4:0] S_COMMIT = 5'd14;
  localparam logic [4:0] S_ARD    = 5'd15;
  localparam logic [4:0] S_AMUL   = 5'd16;
  localparam logic [4:0] S_ACMP   = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  logic [4:0]      state, state_next;
  logic            j, j_next;
  logic [3:0]      dcnt, dcnt_next;
  logic [CNTW-1:0] k_next;
  logic [CW-1:0]   alpha_count;
  logic [CNTW-1:0] cnt_eff;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);

  // alpha_count above the table size is clamped
  assign cnt_eff = (32'(alpha_count) > MAX_ALPHAS) ? CNTW'(MAX_ALPHAS)
                                                   : CNTW'(alpha_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      j           <= 1'b0;
      dcnt        <= '0;
      k           <= '0;
      alpha_count <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      dcnt  <= dcnt_next;
      k     <= k_next;
      if (cfg_valid) begin
        alpha_count <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next   = state;
    j_next       = j;
    dcnt_next    = dcnt;
    k_next       = k;
    cmd.op       = DP_NOP;
    cmd.j        = j;
    cmd.first    = (k == '0);
    cmd.no_lines = (cnt_eff == '0);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        unique case (sts.op) inside
          OP_RESET:                  cmd.op = DP_BRESET;
          OP_TRANS, OP_OBS, OP_ALPHA: cmd.op = DP_WRITE;
          OP_UPDATE: begin
            j_next     = 1'b0;
            state_next = S_RD0;
          end
          default: cmd.op = DP_NOP;
        endcase
      end
      S_RD0: begin cmd.op = DP_RD0; state_next = S_RD1; end
      S_RD1: begin cmd.op = DP_RD1; state_next = S_M1;  end
      S_M1:  begin cmd.op = DP_M1;  state_next = S_ADD; end
      S_ADD: begin cmd.op = DP_ADD; state_next = S_ML;  end
      S_ML:  begin cmd.op = DP_ML;  state_next = S_MH;  end
      S_MH:  begin cmd.op = DP_MH;  state_next = S_U;   end
      S_U: begin
        cmd.op = DP_U;
        if (!j) begin
          j_next     = 1'b1;
          state_next = S_RD0;
        end else begin
          state_next = S_TOT;
        end
      end
      S_TOT: begin cmd.op = DP_TOT; state_next = S_CHK; end
      S_CHK: begin
        j_next     = 1'b0;
        state_next = sts.tot_zero ? S_COMMIT : S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = DP_DINIT;
        dcnt_next  = '0;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op    = DP_DSTEP;
        dcnt_next = dcnt + 4'd1;
        if (dcnt == 4'(DIV_STEPS - 1)) begin
          state_next = S_DRND;
        end
      end
      S_DRND: begin
        cmd.op = DP_DRND;
        if (!j) begin
          j_next     = 1'b1;
          state_next = S_DINIT;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op     = DP_COMMIT;
        k_next     = '0;
        state_next = (cnt_eff == '0) ? S_FIN : S_ARD;
      end
      S_ARD:  begin cmd.op = DP_ARD;  state_next = S_AMUL; end
      S_AMUL: begin cmd.op = DP_AMUL; state_next = S_ACMP; end
      S_ACMP: begin
        cmd.op = DP_ACMP;
        k_next = k + CNTW'(1);
        state_next = (k == cnt_eff - CNTW'(1)) ? S_FIN : S_ARD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op     = DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second item taken while one is in work");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_OUT) |-> sts.out_free)
    else $error("result written over an untaken beat");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ARD) |-> (k < cnt_eff))
    else $error("alpha scan past the line count");

endmodule

[src/pbu_dp.sv]
// ----------------------------------------------------------------------------
// pbu_dp: datapath of the belief update block
// Tables, belief registers, shared multiplier, serial divider, alpha scan.
// ----------------------------------------------------------------------------
module pbu_dp #(
  parameter int NUM_ACTIONS      = pbu_pkg::NUM_ACTIONS_DEF,
  parameter int NUM_OBSERVATIONS = pbu_pkg::NUM_OBSERVATIONS_DEF,
  parameter int MAX_ALPHAS       = pbu_pkg::MAX_ALPHAS_DEF,
  parameter int CNTW             = $clog2(MAX_ALPHAS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbu_pkg::cmd_t        cmd,
  input  logic [CNTW-1:0]      k,
  output pbu_pkg::sts_t        sts,
  input  pbu_pkg::in_item_t    item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pbu_pkg::out_item_t   result
);
  import pbu_pkg::*;

  localparam int TD  = 4 * NUM_ACTIONS;
  localparam int OD  = 2 * NUM_ACTIONS * NUM_OBSERVATIONS;
  localparam int TAW = $clog2(TD);
  localparam int OAW = $clog2(OD);
  localparam int AAW = (MAX_ALPHAS > 1) ? $clog2(MAX_ALPHAS) : 1;
  localparam int ALW = 4 + 32 + 32;

  in_item_t itm;

  logic [PW-1:0]  belief [2];
  logic [PW-1:0]  nb [2];
  logic [UW-1:0]  u [2];
  logic [PW-1:0]  oreg;
  logic [SW-1:0]  prod;
  logic [SW-1:0]  acc;
  logic [SW-1:0]  uacc;
  logic [TW-1:0]  total;
  logic           tot_zero;
  logic [RW-1:0]  rem;
  logic [QW-1:0]  quo;
  logic           big;
  logic signed [49:0]  aprod;
  logic signed [31:0]  aicpt;
  logic [3:0]          aact;
  logic signed [AVW-1:0] best;
  logic [3:0]          best_act;

  logic           act_ok, obs_ok, slot_ok;
  logic [PW-1:0]  prob_sat;
  logic           t_we, o_we, a_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [PW-1:0]  t_rdata, o_rdata;
  logic [ALW-1:0] a_rdata;
  logic           rd_s;
  logic [PW-1:0]  mul_a, mul_b;
  logic [SW-1:0]  mul_p;
  logic [UW-1:0]  uval;
  logic [TW-1:0]  num;
  logic [RW-1:0]  r2;
  logic signed [AVW-1:0] aval;

  assign act_ok  = 32'(itm.act_index) < NUM_ACTIONS;
  assign obs_ok  = 32'(itm.obs_index) < NUM_OBSERVATIONS;
  assign slot_ok = 32'(itm.alpha_slot) < MAX_ALPHAS;
  assign prob_sat = (itm.probability > ONE_Q16) ? ONE_Q16 : itm.probability;

  assign t_we = (cmd.op == DP_WRITE) && (itm.action == OP_TRANS) && act_ok;
  assign o_we = (cmd.op == DP_WRITE) && (itm.action == OP_OBS) && act_ok && obs_ok;
  assign a_we = (cmd.op == DP_WRITE) && (itm.action == OP_ALPHA) && slot_ok;

  // T[s][a][j] at (s*A + a)*2 + j; O[j][a][o] at (j*A + a)*O + o
  assign t_waddr = TAW'((32'(itm.from_state) * NUM_ACTIONS + 32'(itm.act_index)) * 2
                        + 32'(itm.to_state));
  assign o_waddr = OAW'((32'(itm.from_state) * NUM_ACTIONS + 32'(itm.act_index))
                        * NUM_OBSERVATIONS + 32'(itm.obs_index));
  assign rd_s    = (cmd.op == DP_RD1);
  assign t_raddr = TAW'((32'(rd_s) * NUM_ACTIONS + 32'(itm.act_index)) * 2 + 32'(cmd.j));
  assign o_raddr = OAW'((32'(cmd.j) * NUM_ACTIONS + 32'(itm.act_index))
                        * NUM_OBSERVATIONS + 32'(itm.obs_index));

  pbu_ram #(.WIDTH(PW), .DEPTH(TD)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(prob_sat),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  pbu_ram #(.WIDTH(PW), .DEPTH(OD)) u_obs (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(prob_sat),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  pbu_ram #(.WIDTH(ALW), .DEPTH(MAX_ALPHAS)) u_alpha (
    .clk(clk), .we(a_we), .waddr(AAW'(itm.alpha_slot)),
    .wdata({itm.alpha_choice, itm.alpha_slope, itm.alpha_intercept}),
    .raddr(k[AAW-1:0]), .rdata(a_rdata)
  );

  // shared 17x17 multiplier
  always_comb begin
    mul_a = t_rdata;
    mul_b = belief[0];
    case (cmd.op)
      DP_M1:   mul_b = belief[1];
      DP_ML: begin mul_a = oreg; mul_b = acc[16:0];  end
      DP_MH: begin mul_a = oreg; mul_b = acc[33:17]; end
      default: mul_b = belief[0];
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign uval = UW'(uacc) + (UW'(prod) << 17);
  assign num  = TW'(u[cmd.j]);
  assign r2   = {rem[RW-2:0], 1'b0};
  assign aval = AVW'(aprod) + (AVW'(aicpt) <<< 16);

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      itm <= item;
    end
    case (cmd.op)
      DP_RD1: begin
        prod <= mul_p;
        oreg <= o_rdata;
      end
      DP_M1: begin
        prod <= mul_p;
        acc  <= prod;
      end
      DP_ADD: acc <= acc + prod;
      DP_ML:  prod <= mul_p;
      DP_MH: begin
        prod <= mul_p;
        uacc <= prod;
      end
      DP_U:   u[cmd.j] <= (act_ok && obs_ok) ? uval : '0;
      DP_TOT: total <= TW'(u[0]) + TW'(u[1]);
      DP_DINIT: begin
        big <= (num >= total);
        rem <= (num >= total) ? '0 : RW'(num);
        quo <= '0;
      end
      DP_DSTEP: begin
        if (r2 >= RW'(total)) begin
          rem <= r2 - RW'(total);
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= r2;
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
      DP_DRND: nb[cmd.j] <= big ? ONE_Q16 : (PW'(quo) + PW'(r2 >= RW'(total)));
      DP_AMUL: begin
        aprod <= $signed(a_rdata[63:32]) * $signed({1'b0, belief[1]});
        aicpt <= $signed(a_rdata[31:0]);
        aact  <= a_rdata[67:64];
      end
      DP_ACMP: begin
        if (cmd.first || (aval > best)) begin
          best     <= aval;
          best_act <= aact;
        end
      end
      DP_OUT: begin
        result.belief_first  <= belief[0];
        result.belief_second <= belief[1];
        result.chosen_action <= cmd.no_lines ? 4'd0 : best_act;
        result.status        <= tot_zero ? ST_ZERO_TOT :
                                cmd.no_lines ? ST_NO_LINES : ST_OK;
      end
      default: ;
    endcase
  end

  // belief, zero flag and result valid carry reset
  always_ff @(posedge clk) begin
    if (rst) begin
      belief[0]    <= HALF_Q16;
      belief[1]    <= HALF_Q16;
      tot_zero     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.op == DP_BRESET) begin
        belief[0] <= HALF_Q16;
        belief[1] <= HALF_Q16;
      end else if (cmd.op == DP_COMMIT && !tot_zero) begin
        belief[0] <= nb[0];
        belief[1] <= nb[1];
      end
      if (cmd.op == DP_TOT) begin
        tot_zero <= (u[0] == '0) && (u[1] == '0);
      end
      if (cmd.op == DP_OUT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.op       = itm.action;
  assign sts.tot_zero = tot_zero;
  assign sts.out_free = !result_valid || result_ready;

  a_belief_sum: assert property (@(posedge clk) disable iff (rst)
    ((18'(belief[0]) + 18'(belief[1])) >= 18'd65535) &&
    ((18'(belief[0]) + 18'(belief[1])) <= 18'd65537))
    else $error("belief entries do not sum to one");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_DSTEP) |-> (rem < RW'(total)))
    else $error("divider remainder not below total");

  a_out_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_OUT) |=> result_valid)
    else $error("result beat not raised");

endmodule

[src/pomdp_belief_update_action_select.sv]
// ----------------------------------------------------------------------------
// pomdp_belief_update_action_select: two-state belief tracker with policy
// Bayes belief update over loaded tables and alpha-line action selection.
// ----------------------------------------------------------------------------
// Usage:
//   item channel  (item_valid/item_ready/item): one beat per command. Codes
//     reset belief, load transition, load observation and load alpha line
//     write state and give no result; update gives exactly one result beat.
//   result channel (result_valid/result_ready/result): beliefs, chosen
//     action and status. The result sits in an output register, so the
//     block takes the next item while that beat waits.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): alpha_count, always ready.
// Timing: one item is in work at a time. An update makes two passes
//   through the shared 17x17 multiplier, two restoring divisions (both
//   skipped with a zero total) and a read, multiply and compare step
//   per alpha line; result_valid rises in the same cycle as item_ready
//   for the next item.
// Reset: belief goes to 0.5/0.5, alpha_count to 0; tables hold no value
//   until loaded. If the receiver stalls, a finished update holds in its
//   last step until the previous result beat has been taken.
// ----------------------------------------------------------------------------
module pomdp_belief_update_action_select #(
  parameter int NUM_ACTIONS      = pbu_pkg::NUM_ACTIONS_DEF,
  parameter int NUM_OBSERVATIONS = pbu_pkg::NUM_OBSERVATIONS_DEF,
  parameter int MAX_ALPHAS       = pbu_pkg::MAX_ALPHAS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pbu_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output pbu_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);
  import pbu_pkg::*;

  // scan counter must hold the line count itself
  localparam int CNTW = $clog2(MAX_ALPHAS + 1);

  cmd_t            cmd;
  sts_t            sts;
  logic [CNTW-1:0] k;

  pbu_ctrl #(
    .MAX_ALPHAS(MAX_ALPHAS),
    .CNTW(CNTW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .k(k),
    .sts(sts)
  );

  pbu_dp #(
    .NUM_ACTIONS(NUM_ACTIONS),
    .NUM_OBSERVATIONS(NUM_OBSERVATIONS),
    .MAX_ALPHAS(MAX_ALPHAS),
    .CNTW(CNTW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .k(k),
    .sts(sts),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule

[dv/pbu_checker.sv]
// ----------------------------------------------------------------------------
// pbu_checker: belief update scoreboard
// Watches item, cfg and result beats and keeps its own copy of the belief,
// the tables and alpha_count. It predicts the result of each update and
// compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module pbu_checker
  import pbu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  in_item_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_item_t result,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [4:0] cfg_data,
  output int        mismatches,
  output int        outstanding
);

  logic [16:0] belief [2];
  logic [16:0] trans_p [16];
  logic [16:0] obs_p [32];
  logic [3:0]  line_act [16];
  logic [31:0] line_slope [16];
  logic [31:0] line_icpt [16];
  logic [4:0]  line_count;
  out_item_t   pending_q [$];

  // round(num * 65536 / den), restoring division
  function automatic logic [16:0] norm_div(longint unsigned num, longint unsigned den);
    longint unsigned r;
    logic [16:0] q;
    r = num;
    q = '0;
    if (num >= den) return ONE_Q16;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= den) q = q + 17'd1;
    return q;
  endfunction

  function automatic out_item_t predict_update(logic [1:0] a, logic [1:0] o);
    longint unsigned u [2];
    longint unsigned sum, total;
    longint best, v;
    out_item_t res;
    int lines;
    res = '0;
    total = 0;
    best = 0;
    for (int j = 0; j < 2; j++) begin
      sum = 0;
      for (int s = 0; s < 2; s++)
        sum += longint'(trans_p[4'((s * 4 + a) * 2 + j)]) * longint'(belief[1'(s)]);
      u[1'(j)] = longint'(obs_p[5'((j * 4 + a) * 4 + o)]) * sum;
      total += u[1'(j)];
    end
    if (total == 0) res.status = ST_ZERO_TOT;
    else for (int j = 0; j < 2; j++) belief[1'(j)] = norm_div(u[1'(j)], total);
    lines = (line_count > 16) ? 16 : line_count;
    if (lines == 0) begin
      if (res.status == ST_OK) res.status = ST_NO_LINES;
    end else begin
      for (int k = 0; k < lines; k++) begin
        v = longint'($signed(line_slope[4'(k)])) * longint'(belief[1])
            + longint'($signed(line_icpt[4'(k)])) * 65536;
        if (k == 0 || v > best) begin
          best = v;
          res.chosen_action = line_act[4'(k)];
        end
      end
    end
    res.belief_first  = belief[0];
    res.belief_second = belief[1];
    return res;
  endfunction

  always @(posedge clk) begin
    logic [16:0] p;
    out_item_t want;
    if (rst) begin
      belief[0] = HALF_Q16;
      belief[1] = HALF_Q16;
      line_count = '0;
      pending_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) line_count = cfg_data;
      if (item_valid && item_ready) begin
        p = (item.probability > ONE_Q16) ? ONE_Q16 : item.probability;
        case (item.action)
          OP_RESET: begin
            belief[0] = HALF_Q16;
            belief[1] = HALF_Q16;
          end
          OP_TRANS:
            trans_p[4'((item.from_state * 4 + item.act_index) * 2 + item.to_state)] = p;
          OP_OBS:
            obs_p[5'((item.from_state * 4 + item.act_index) * 4 + item.obs_index)] = p;
          OP_ALPHA: begin
            line_act[item.alpha_slot]   = item.alpha_choice;
            line_slope[item.alpha_slot] = item.alpha_slope;
            line_icpt[item.alpha_slot]  = item.alpha_intercept;
          end
          OP_UPDATE: pending_q = {pending_q, predict_update(item.act_index, item.obs_index)};
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, result);
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          if (result.belief_first !== want.belief_first) begin
            $display("%0t: belief_first exp %0d got %0d", $time,
                     want.belief_first, result.belief_first);
            mismatches++;
          end
          if (result.belief_second !== want.belief_second) begin
            $display("%0t: belief_second exp %0d got %0d", $time,
                     want.belief_second, result.belief_second);
            mismatches++;
          end
          if (result.chosen_action !== want.chosen_action) begin
            $display("%0t: chosen_action exp %0d got %0d", $time,
                     want.chosen_action, result.chosen_action);
            mismatches++;
          end
          if (result.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, result.status);
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_q.size();
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: top of the belief update testbench
// Drives item beats with random gaps and cfg beats, stalls the result side, and
// leaves prediction and checking to pbu_checker. Prints the verdict.
// ----------------------------------------------------------------------------
module tb;
  import pbu_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [4:0] cfg_data = '0;
  int        mismatches;
  int        outstanding;

  bit no_idle;     // stretch with back-to-back beats
  bit long_hold;   // request a long result stall

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pomdp_belief_update_action_select DUT (
    .clk, .rst, .item_valid, .item_ready, .item,
    .result_valid, .result_ready, .result,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  pbu_checker scoreboard (
    .clk, .rst, .item_valid, .item_ready, .item,
    .result_valid, .result_ready, .result,
    .cfg_valid, .cfg_ready, .cfg_data,
    .mismatches, .outstanding
  );

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all pending updates, let the block settle, then write alpha_count.
  task automatic write_count(logic [4:0] v);
    item_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (120) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] rand_prob();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE_Q16;
      2: return 17'($urandom_range(65537, 131071));  // saturates
      3: return 17'($urandom_range(0, 255));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 3)) << 16;  // small values make ties
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.action          = OP_UPDATE;
    it.from_state      = 1'($urandom);
    it.to_state        = 1'($urandom);
    it.act_index       = 2'($urandom);
    it.obs_index       = 2'($urandom);
    it.probability     = rand_prob();
    it.alpha_slot      = 4'($urandom);
    it.alpha_choice    = 4'($urandom);
    it.alpha_slope     = rand_q16();
    it.alpha_intercept = rand_q16();
    return it;
  endfunction

  // Mostly updates; table reloads keep the posterior moving.
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    it = rand_fields();
    pick = $urandom_range(0, 99);
    if (pick < 55)      it.action = OP_UPDATE;
    else if (pick < 70) it.action = OP_TRANS;
    else if (pick < 85) it.action = OP_OBS;
    else if (pick < 93) it.action = OP_ALPHA;
    else if (pick < 97) it.action = OP_RESET;
    else                it.action = 3'($urandom_range(5, 7));  // unused codes
    return it;
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic fs, logic ts, logic [1:0] a,
                                  logic [1:0] o, logic [16:0] p);
    in_item_t it;
    it = rand_fields();
    it.action = op;
    it.from_state = fs;
    it.to_state = ts;
    it.act_index = a;
    it.obs_index = o;
    it.probability = p;
    return it;
  endfunction

  // Receiver: random stall per beat, one long hold on request.
  initial begin
    int w;
    @(negedge clk);
    wait (!rst);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 12);
      if (long_hold) begin
        w = 700;
        long_hold = 1'b0;
      end
      if (w > 0) begin
        result_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    in_item_t it;
    logic [4:0] counts [6] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill every table entry so no update reads an unloaded one.
    for (int i = 0; i < 16; i++)
      send(mk(OP_TRANS, i[3], i[0], i[2:1], 2'd0, rand_prob()));
    for (int i = 0; i < 32; i++)
      send(mk(OP_OBS, i[4], 1'b0, i[3:2], i[1:0], rand_prob()));
    for (int i = 0; i < 16; i++) begin
      it = rand_fields();
      it.action = OP_ALPHA;
      it.alpha_slot = 4'(i);
      send(it);
    end

    // Directed: no alpha lines, unused codes, zero normalizer.
    send(mk(OP_UPDATE, 1'b0, 1'b0, 2'd0, 2'd0, '0));
    send(mk(3'd5, 1'b0, 1'b0, 2'd0, 2'd0, '0));
    send(mk(3'd6, 1'b0, 1'b0, 2'd0, 2'd0, '0));
    send(mk(3'd7, 1'b0, 1'b0, 2'd0, 2'd0, '0));
    send(mk(OP_RESET, 1'b0, 1'b0, 2'd0, 2'd0, '0));
    send(mk(OP_OBS, 1'b0, 1'b0, 2'd3, 2'd3, '0));
    send(mk(OP_OBS, 1'b1, 1'b0, 2'd3, 2'd3, '0));
    send(mk(OP_UPDATE, 1'b0, 1'b0, 2'd3, 2'd3, '0));  // zero total beats no-lines
    write_count(5'd16);
    // Tied lines: the lower slot must win.
    it = rand_fields();
    it.action = OP_ALPHA;
    it.alpha_slot = 4'd0;
    it.alpha_choice = 4'd15;
    it.alpha_slope = 32'h8000_0000;
    it.alpha_intercept = 32'h7fff_ffff;
    send(it);
    it.alpha_slot = 4'd1;
    it.alpha_choice = 4'd3;
    send(it);
    send(mk(OP_UPDATE, 1'b0, 1'b0, 2'd3, 2'd3, '0));
    send(mk(OP_TRANS, 1'b0, 1'b0, 2'd1, 2'd0, 17'h1ffff));
    send(mk(OP_TRANS, 1'b1, 1'b1, 2'd1, 2'd0, ONE_Q16));
    send(mk(OP_OBS, 1'b0, 1'b0, 2'd1, 2'd2, ONE_Q16));
    send(mk(OP_OBS, 1'b1, 1'b0, 2'd1, 2'd2, 17'd1));
    send(mk(OP_UPDATE, 1'b0, 1'b0, 2'd1, 2'd2, '0));
    send(mk(OP_UPDATE, 1'b0, 1'b0, 2'd1, 2'd2, '0));
    send(mk(OP_RESET, 1'b0, 1'b0, 2'd0, 2'd0, '0));
    send(mk(OP_UPDATE, 1'b0, 1'b0, 2'd1, 2'd2, '0));

    // Random phases, each under its own alpha_count.
    for (int ph = 0; ph < 6; ph++) begin
      write_count(ph == 4 ? 5'($urandom_range(2, 15)) : counts[3'(ph)]);
      if (ph == 2) long_hold = 1'b1;  // block fills and stalls items
      for (int n = 0; n < 111; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        send(rand_item());
      end
      no_idle = 1'b0;
    end

    item_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (150) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[pomdp_belief_update_action_select.f]
src/pbu_pkg.sv
src/pbu_ram.sv
src/pbu_ctrl.sv
src/pbu_dp.sv
src/pomdp_belief_update_action_select.sv
dv/pbu_checker.sv
dv/tb.sv
